@@ hdl/bhtoc_pkg.sv @@
// ----------------------------------------------------------------------------
// bhtoc_pkg
// Shared codes and constants of the bucketized hash table with overflow chains.
// ----------------------------------------------------------------------------
package bhtoc_pkg;

    localparam int KEY_W    = 64;
    localparam int REC_W    = 64;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;
    localparam int ENT_W    = 9;
    localparam int CFG_W    = 7;
    localparam int IN_W     = 136;
    localparam int OUT_W    = 80;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_PUT    = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;

    localparam logic [1:0] SLOT_FREE  = 2'd0;
    localparam logic [1:0] SLOT_OCC   = 2'd1;
    localparam logic [1:0] SLOT_TOMB  = 2'd2;

    localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
    localparam int          MIX_SH = 33;

    localparam logic [CFG_W-1:0] BUCKETS_RESET = 7'd16;

endpackage

@@ hdl/bucket_hash_table_overflow_chain.sv @@
// ----------------------------------------------------------------------------
// bucket_hash_table_overflow_chain
// Key/record store: hashed primary pages with chained overflow pages.
// ----------------------------------------------------------------------------
// One item at a time. An item is accepted, then hashed (two 64-bit multiplies,
// each as three 32x32 partial products on one multiplier), then reduced by the
// modulo (4 quotient bits a cycle). Each page walked in the chain is then read
// from a registered memory, and all slots of the page are compared together.
// When an overflow page is linked, the link is written in a state of its own.
// The result is then handed off, waiting while the output is held. The store
// is empty right after reset; there is no clearing pass. Writing
// primary_buckets also clears the store.
module bucket_hash_table_overflow_chain
    import bhtoc_pkg::*;
#(
    parameter int SLOTS_PER_PAGE = 4,
    parameter int PAGE_COUNT     = 64,
    parameter int RECORD_BITS    = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    // command [1:0], key [65:2], record [129:66]
    input  logic [IN_W-1:0]   s_axis_tdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // status [1:0], record_out [65:2], entries [74:66]
    output logic [OUT_W-1:0]  m_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int S    = SLOTS_PER_PAGE;
    localparam int PW   = $clog2(PAGE_COUNT);
    localparam int LW   = (S > 1) ? $clog2(S) : 1;
    localparam int NBW  = ($clog2(PAGE_COUNT + 1) > CFG_W) ? $clog2(PAGE_COUNT + 1) : CFG_W;
    localparam int ETW  = $clog2(PAGE_COUNT * S + 1);
    localparam int DIV_STEPS = 4;
    localparam int DIV_CYC   = KEY_W / DIV_STEPS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_EVAL = 3'd4;
    localparam logic [2:0] ST_LINK = 3'd5;
    localparam logic [2:0] ST_RESP = 3'd6;

    typedef struct packed {
        logic [PW-1:0]      link;
        logic [S-1:0][1:0]  st;
    } meta_t;

    typedef struct packed {
        logic [KEY_W-1:0]       key;
        logic [RECORD_BITS-1:0] rec;
    } slot_t;

    meta_t meta_mem [PAGE_COUNT];
    slot_t data_mem [PAGE_COUNT][S];
    meta_t meta_rd_q;
    slot_t data_rd_q [S];

    logic [2:0]             state_reg, state_next;
    logic [CFG_W-1:0]       buckets_reg;
    logic [PAGE_COUNT-1:0]  pg_valid_reg, pg_valid_next;
    logic [PW:0]            ovf_reg, ovf_next;
    logic [ETW-1:0]         entry_reg, entry_next;
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [RECORD_BITS-1:0] rec_reg, rec_next;
    logic [63:0]            h_reg, h_next;
    logic [63:0]            acc_reg, acc_next;
    logic [1:0]             mstep_reg, mstep_next;
    logic                   msel_reg, msel_next;
    logic [NBW-1:0]         rem_reg, rem_next;
    logic [$clog2(DIV_CYC)-1:0] dcnt_reg, dcnt_next;
    logic [PW-1:0]          page_reg, page_next;
    logic [PW-1:0]          walk_reg, walk_next;
    logic                   hfree_reg, hfree_next;
    logic [PW-1:0]          fpage_reg, fpage_next;
    logic [LW-1:0]          flane_reg, flane_next;
    meta_t                  fmeta_reg, fmeta_next;
    meta_t                  lmeta_reg, lmeta_next;
    logic [STAT_W-1:0]      rstat_reg, rstat_next;
    logic [REC_W-1:0]       rrec_reg, rrec_next;
    logic                   mvalid_reg, mvalid_next;
    logic [OUT_W-1:0]       mdata_reg, mdata_next;

    logic                   meta_we;
    logic [PW-1:0]          meta_wa;
    meta_t                  meta_wd;
    logic                   data_we;
    logic [PW-1:0]          data_wa;
    logic [LW-1:0]          data_lane;
    slot_t                  data_wd;

    logic                   cfg_wr;
    logic                   in_acc;
    logic [NBW-1:0]         nb;
    logic [NBW:0]           np;
    logic [31:0]            mop_a, mop_b;
    logic [63:0]            mprod, msum;
    logic [NBW:0]           dtmp;
    logic [NBW-1:0]         drem;
    meta_t                  cur_meta;
    logic                   found, cfree, chain_end;
    logic [LW-1:0]          mlane, clane;
    logic [PW-1:0]          use_fpage;
    logic [LW-1:0]          use_flane;
    meta_t                  use_fmeta;
    meta_t                  wmeta;
    logic [KEY_W-1:0]       in_key;

    assign cfg_wr        = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == 1'b0) ? 32'(buckets_reg) : 32'd0;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;
    assign in_key        = s_axis_tdata[KEY_W+1:2];

    always_comb
    begin
        nb = NBW'(buckets_reg);
        if (buckets_reg == '0)
        begin
            nb = NBW'(1);
        end
        else if (NBW'(buckets_reg) > NBW'(PAGE_COUNT))
        begin
            nb = NBW'(PAGE_COUNT);
        end
    end

    assign np = (NBW + 1)'(nb) + (NBW + 1)'(ovf_reg);

    always_comb
    begin
        mop_a = (mstep_reg == 2'd2) ? h_reg[63:32] : h_reg[31:0];
        mop_b = (mstep_reg == 2'd1) ? (msel_reg ? MIX_C2[63:32] : MIX_C1[63:32])
                                    : (msel_reg ? MIX_C2[31:0]  : MIX_C1[31:0]);
    end

    assign mprod = 64'(mop_a) * 64'(mop_b);
    assign msum  = (mstep_reg == 2'd0) ? mprod : acc_reg + {mprod[31:0], 32'd0};

    always_comb
    begin
        drem = rem_reg;
        dtmp = '0;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            dtmp = {drem, h_reg[63-i]};
            if (dtmp >= (NBW + 1)'(nb))
            begin
                dtmp = dtmp - (NBW + 1)'(nb);
            end
            drem = dtmp[NBW-1:0];
        end
    end

    always_comb
    begin
        cur_meta = pg_valid_reg[page_reg] ? meta_rd_q : '0;
        found = 1'b0;
        mlane = '0;
        cfree = 1'b0;
        clane = '0;
        for (int i = 0; i < S; i++)
        begin
            if (cur_meta.st[i] == SLOT_OCC)
            begin
                if (!found && data_rd_q[i].key == key_reg)
                begin
                    found = 1'b1;
                    mlane = LW'(i);
                end
            end
            else if (!cfree)
            begin
                cfree = 1'b1;
                clane = LW'(i);
            end
        end
        chain_end = found || (cur_meta.link == '0)
                    || ((PW + 1)'(cur_meta.link) >= (PW + 1)'(PAGE_COUNT))
                    || (walk_reg == PW'(PAGE_COUNT - 1));
        use_fpage = hfree_reg ? fpage_reg : page_reg;
        use_flane = hfree_reg ? flane_reg : clane;
        use_fmeta = hfree_reg ? fmeta_reg : cur_meta;
    end

    always_comb
    begin
        state_next    = state_reg;
        pg_valid_next = pg_valid_reg;
        ovf_next      = ovf_reg;
        entry_next    = entry_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        rec_next      = rec_reg;
        h_next        = h_reg;
        acc_next      = acc_reg;
        mstep_next    = mstep_reg;
        msel_next     = msel_reg;
        rem_next      = rem_reg;
        dcnt_next     = dcnt_reg;
        page_next     = page_reg;
        walk_next     = walk_reg;
        hfree_next    = hfree_reg;
        fpage_next    = fpage_reg;
        flane_next    = flane_reg;
        fmeta_next    = fmeta_reg;
        lmeta_next    = lmeta_reg;
        rstat_next    = rstat_reg;
        rrec_next     = rrec_reg;
        mvalid_next   = mvalid_reg;
        mdata_next    = mdata_reg;
        meta_we       = 1'b0;
        meta_wa       = page_reg;
        meta_wd       = cur_meta;
        data_we       = 1'b0;
        data_wa       = page_reg;
        data_lane     = mlane;
        data_wd       = '{key: key_reg, rec: rec_reg};
        wmeta         = cur_meta;

        if (mvalid_reg && m_axis_tready)
        begin
            mvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cmd_next   = s_axis_tdata[1:0];
                    key_next   = in_key;
                    rec_next   = s_axis_tdata[RECORD_BITS+65:66];
                    h_next     = in_key ^ (in_key >> MIX_SH);
                    mstep_next = 2'd0;
                    msel_next  = 1'b0;
                    rstat_next = STAT_OK;
                    rrec_next  = '0;
                    if (s_axis_tdata[1:0] == CMD_CLEAR)
                    begin
                        pg_valid_next = '0;
                        ovf_next      = '0;
                        entry_next    = '0;
                        state_next    = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                acc_next = msum;
                if (mstep_reg == 2'd2)
                begin
                    h_next     = msum ^ (msum >> MIX_SH);
                    mstep_next = 2'd0;
                    msel_next  = 1'b1;
                    if (msel_reg)
                    begin
                        rem_next   = '0;
                        dcnt_next  = '0;
                        state_next = ST_DIV;
                    end
                end
                else
                begin
                    mstep_next = mstep_reg + 2'd1;
                end
            end
            ST_DIV:
            begin
                rem_next  = drem;
                h_next    = {h_reg[63-DIV_STEPS:0], {DIV_STEPS{1'b0}}};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == ($clog2(DIV_CYC))'(DIV_CYC - 1))
                begin
                    page_next  = PW'(drem);
                    walk_next  = '0;
                    hfree_next = 1'b0;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!hfree_reg && cfree)
                begin
                    hfree_next = 1'b1;
                    fpage_next = page_reg;
                    flane_next = clane;
                    fmeta_next = cur_meta;
                end
                if (!chain_end)
                begin
                    page_next  = cur_meta.link;
                    walk_next  = walk_reg + 1'b1;
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_RESP;
                    case (cmd_reg)
                        CMD_LOOKUP:
                        begin
                            if (found)
                            begin
                                rrec_next = REC_W'(data_rd_q[mlane].rec);
                            end
                            else
                            begin
                                rstat_next = STAT_NOTFOUND;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (found)
                            begin
                                wmeta.st[mlane] = SLOT_TOMB;
                                meta_we = 1'b1;
                                meta_wa = page_reg;
                                meta_wd = wmeta;
                                if (entry_reg != '0)
                                begin
                                    entry_next = entry_reg - 1'b1;
                                end
                            end
                            else
                            begin
                                rstat_next = STAT_NOTFOUND;
                            end
                        end
                        CMD_PUT:
                        begin
                            if (found)
                            begin
                                data_we   = 1'b1;
                                data_wa   = page_reg;
                                data_lane = mlane;
                            end
                            else if (hfree_reg || cfree)
                            begin
                                wmeta              = use_fmeta;
                                wmeta.st[use_flane] = SLOT_OCC;
                                meta_we    = 1'b1;
                                meta_wa    = use_fpage;
                                meta_wd    = wmeta;
                                data_we    = 1'b1;
                                data_wa    = use_fpage;
                                data_lane  = use_flane;
                                entry_next = entry_reg + 1'b1;
                            end
                            else if (np >= (NBW + 1)'(PAGE_COUNT))
                            begin
                                rstat_next = STAT_FULL;
                            end
                            else
                            begin
                                wmeta       = '0;
                                wmeta.st[0] = SLOT_OCC;
                                meta_we     = 1'b1;
                                meta_wa     = np[PW-1:0];
                                meta_wd     = wmeta;
                                data_we     = 1'b1;
                                data_wa     = np[PW-1:0];
                                data_lane   = '0;
                                ovf_next    = ovf_reg + 1'b1;
                                entry_next  = entry_reg + 1'b1;
                                lmeta_next      = cur_meta;
                                lmeta_next.link = np[PW-1:0];
                                state_next  = ST_LINK;
                            end
                        end
                        default:
                        begin
                            rstat_next = STAT_OK;
                        end
                    endcase
                end
            end
            ST_LINK:
            begin
                meta_we    = 1'b1;
                meta_wa    = page_reg;
                meta_wd    = lmeta_reg;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!mvalid_reg || m_axis_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = OUT_W'({ENT_W'(entry_reg), rrec_reg, rstat_reg});
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (meta_we)
        begin
            pg_valid_next[meta_wa] = 1'b1;
        end

        if (cfg_wr)
        begin
            pg_valid_next = '0;
            ovf_next      = '0;
            entry_next    = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_wa] <= meta_wd;
        end
        meta_rd_q <= meta_mem[page_reg];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < S; i++)
        begin
            if (data_we && data_lane == LW'(i))
            begin
                data_mem[data_wa][i] <= data_wd;
            end
            data_rd_q[i] <= data_mem[page_reg][i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            buckets_reg  <= BUCKETS_RESET;
            pg_valid_reg <= '0;
            ovf_reg      <= '0;
            entry_reg    <= '0;
            mvalid_reg   <= 1'b0;
            hfree_reg    <= 1'b0;
            mstep_reg    <= '0;
            msel_reg     <= 1'b0;
            dcnt_reg     <= '0;
            walk_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pg_valid_reg <= pg_valid_next;
            ovf_reg      <= ovf_next;
            entry_reg    <= entry_next;
            mvalid_reg   <= mvalid_next;
            hfree_reg    <= hfree_next;
            mstep_reg    <= mstep_next;
            msel_reg     <= msel_next;
            dcnt_reg     <= dcnt_next;
            walk_reg     <= walk_next;
            if (cfg_wr)
            begin
                buckets_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        rec_reg   <= rec_next;
        h_reg     <= h_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        page_reg  <= page_next;
        fpage_reg <= fpage_next;
        flane_reg <= flane_next;
        fmeta_reg <= fmeta_next;
        lmeta_reg <= lmeta_next;
        rstat_reg <= rstat_next;
        rrec_reg  <= rrec_next;
        mdata_reg <= mdata_next;
    end

endmodule

@@ dv/bhtoc_checker.sv @@
// ----------------------------------------------------------------------------
// bhtoc_checker
// Watches the command and response streams and the register port of the hash
// table, predicts each response from a private copy of the store and compares
// it field by field with what the block returns.
// ----------------------------------------------------------------------------
module bhtoc_checker
    import bhtoc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IN_W-1:0]   s_axis_tdata,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [OUT_W-1:0]  m_axis_tdata,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 4;
    localparam int PAGES = 64;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [REC_W-1:0]  record_out;
        logic [ENT_W-1:0]  entries;
    } response_t;

    logic [1:0]        slot_st  [PAGES*SLOTS];
    logic [KEY_W-1:0]  slot_key [PAGES*SLOTS];
    logic [REC_W-1:0]  slot_rec [PAGES*SLOTS];
    logic [5:0]        next_page [PAGES];
    int                ovf_used;
    int                occupied;
    logic [CFG_W-1:0]  buckets;
    response_t         resp_q[$];

    function automatic logic [63:0] scramble(logic [63:0] h);
        h = h ^ (h >> MIX_SH);
        h = h * MIX_C1;
        h = h ^ (h >> MIX_SH);
        h = h * MIX_C2;
        h = h ^ (h >> MIX_SH);
        return h;
    endfunction

    function automatic void wipe_store();
        for (int i = 0; i < PAGES*SLOTS; i++)
            slot_st[i] = SLOT_FREE;
        for (int p = 0; p < PAGES; p++)
            next_page[p] = '0;
        ovf_used = 0;
        occupied = 0;
    endfunction

    function automatic response_t apply_command(logic [1:0] cmd, logic [63:0] key,
                                                logic [63:0] rec);
        response_t r;
        int nb, page, tail, hit, free_s, np;
        bit found, have_free;
        r = '0;
        if (cmd == CMD_CLEAR)
        begin
            wipe_store();
        end
        else
        begin
            nb = (buckets == 0) ? 1 : ((buckets > PAGES) ? PAGES : int'(buckets));
            page = int'(scramble(key) % 64'(nb));
            tail = page;
            found = 0;
            have_free = 0;
            hit = 0;
            free_s = 0;
            for (int w = 0; w < PAGES && !found; w++)
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_st[page*SLOTS+i] == SLOT_OCC)
                    begin
                        if (slot_key[page*SLOTS+i] == key)
                        begin
                            found = 1;
                            hit = page*SLOTS+i;
                            break;
                        end
                    end
                    else if (!have_free)
                    begin
                        have_free = 1;
                        free_s = page*SLOTS+i;
                    end
                end
                tail = page;
                if (found || next_page[page] == 0) break;
                page = next_page[page];
            end
            if (cmd == CMD_LOOKUP)
            begin
                if (found) r.record_out = slot_rec[hit];
                else r.status = STAT_NOTFOUND;
            end
            else if (cmd == CMD_DELETE)
            begin
                if (found)
                begin
                    slot_st[hit] = SLOT_TOMB;
                    if (occupied > 0) occupied--;
                end
                else r.status = STAT_NOTFOUND;
            end
            else if (found)
            begin
                slot_rec[hit] = rec;
            end
            else if (have_free)
            begin
                slot_st[free_s] = SLOT_OCC;
                slot_key[free_s] = key;
                slot_rec[free_s] = rec;
                occupied++;
            end
            else
            begin
                np = nb + ovf_used;
                if (np >= PAGES)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    ovf_used++;
                    for (int i = 0; i < SLOTS; i++)
                        slot_st[np*SLOTS+i] = SLOT_FREE;
                    next_page[np] = '0;
                    slot_st[np*SLOTS] = SLOT_OCC;
                    slot_key[np*SLOTS] = key;
                    slot_rec[np*SLOTS] = rec;
                    next_page[tail] = 6'(np);
                    occupied++;
                end
            end
        end
        r.entries = ENT_W'(occupied);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        response_t want;
        logic [STAT_W-1:0] got_st;
        logic [REC_W-1:0]  got_rec;
        logic [ENT_W-1:0]  got_ent;
        if (!rst_n)
        begin
            buckets = BUCKETS_RESET;
            wipe_store();
            resp_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_st  = m_axis_tdata[1:0];
                got_rec = m_axis_tdata[65:2];
                got_ent = m_axis_tdata[74:66];
                if (resp_q.size() == 0)
                begin
                    $error("response with no command outstanding");
                    fail_count++;
                end
                else
                begin
                    want = resp_q.pop_front();
                    if (got_st !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got_st);
                        fail_count++;
                    end
                    if (got_rec !== want.record_out)
                    begin
                        $error("record_out: expected %h, got %h", want.record_out, got_rec);
                        fail_count++;
                    end
                    if (got_ent !== want.entries)
                    begin
                        $error("entries: expected %0d, got %0d", want.entries, got_ent);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                resp_q.push_back(apply_command(s_axis_tdata[1:0], s_axis_tdata[65:2],
                                               s_axis_tdata[129:66]));
            if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
            begin
                buckets = pwdata[CFG_W-1:0];
                wipe_store();
            end
            pending = resp_q.size();
        end
    end
endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random lookup/put/delete/clear traffic into the hash
// table across several bucket counts, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;
    import bhtoc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 5000;
    localparam int SETTLE     = 300;

    logic              clk;
    logic              rst_n;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    int                fail_count;
    int                pending;
    bit                quiet;
    int                idle_cycles;
    logic [63:0]       key_pool[320];
    int                pool_n;

    bucket_hash_table_overflow_chain i_dut (.*);

    bhtoc_checker i_checker (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        m_axis_tready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 9) == 0)
            begin
                m_axis_tready <= 0;
                repeat ($urandom_range(1, 18)) @(negedge clk);
            end
            m_axis_tready <= 1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send(logic [1:0] cmd, logic [63:0] key, logic [63:0] rec);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_axis_tdata  <= {6'd0, rec, key, cmd};
        s_axis_tvalid <= 1;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic set_buckets(logic [31:0] value);
        s_axis_tvalid <= 0;
        wait (pending == 0);
        repeat (SETTLE) @(negedge clk);
        psel    <= 1;
        pwrite  <= 1;
        paddr   <= 3'd0;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_phase(int n, int pool);
        logic [1:0]  cmd;
        logic [63:0] key;
        int pick;
        for (int i = 0; i < pool; i++)
            key_pool[i] = rand64();
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50) cmd = CMD_PUT;
            else if (pick < 75) cmd = CMD_LOOKUP;
            else if (pick < 99) cmd = CMD_DELETE;
            else cmd = CMD_CLEAR;
            key = ($urandom_range(0, 19) == 0) ? rand64() : key_pool[$urandom_range(0, pool-1)];
            send(cmd, key, rand64());
        end
    endtask

    initial
    begin
        logic [31:0] settings[6] = '{32'd1, 32'd64, 32'd0, 32'd127, 32'd5, 32'd16};
        quiet = 0;
        idle_cycles = 0;
        rst_n = 0;
        s_axis_tdata = '0;
        s_axis_tvalid = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        send(CMD_LOOKUP, 64'd0, 64'd0);
        send(CMD_DELETE, 64'd0, 64'd0);
        send(CMD_PUT, 64'd0, 64'd0);
        send(CMD_PUT, '1, '1);
        send(CMD_LOOKUP, 64'd0, '1);
        send(CMD_LOOKUP, '1, 64'd0);
        send(CMD_PUT, '1, 64'h5555_5555_5555_5555);
        send(CMD_LOOKUP, '1, 64'd0);
        send(CMD_PUT, 64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
        send(CMD_DELETE, 64'd0, 64'd0);
        send(CMD_LOOKUP, 64'd0, 64'd0);
        send(CMD_DELETE, 64'd0, 64'd0);
        send(CMD_PUT, 64'd0, 64'd7);
        send(CMD_CLEAR, 64'd0, 64'd0);
        send(CMD_LOOKUP, '1, 64'd0);
        set_buckets(32'd1);
        for (int i = 0; i < 8; i++)
            send(CMD_PUT, 64'(i), rand64());
        send(CMD_LOOKUP, 64'd7, 64'd0);

        for (int ph = 0; ph < 6; ph++)
        begin
            set_buckets(ph == 5 ? 32'($urandom_range(2, 63)) : settings[ph]);
            if (ph == 0)
                random_phase(400, 300);
            else
                random_phase(300, ph == 1 ? 320 : $urandom_range(20, 320));
        end
        quiet = 1;
        random_phase(30, 100);
        s_axis_tvalid <= 0;

        wait (pending == 0);
        repeat (SETTLE) @(negedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
